// ===== hdl/chss_pkg.sv =====
// shared types, codes and the half-step coil table for the stepper sequencer
package chss_pkg;

  localparam int unsigned DEGREE_W = 9;
  localparam int unsigned SWEEP_W  = 10;
  localparam int unsigned DELAY_W  = 16;
  localparam int unsigned PHASES   = 8;
  localparam int unsigned PHASE_W  = $clog2(PHASES);

  localparam logic [DEGREE_W-1:0] DEGREES_PER_TURN = 9'd360;
  localparam logic [DELAY_W-1:0]  STEP_DELAY_RESET = 16'd1000;
  localparam logic [DEGREE_W-1:0] MAX_ANGLE_RESET  = 9'd90;

  // floor(512 * deg / 360) == (deg * SWEEP_RECIP) >> SWEEP_SHIFT for deg up to 360
  localparam int unsigned         SWEEP_SHIFT = 15;
  localparam logic [15:0]         SWEEP_RECIP = 16'd46604;
  localparam int unsigned         PROD_W      = DEGREE_W + 16;

  typedef enum logic [1:0] {
    ACT_TICK    = 2'd0,
    ACT_MOVE    = 2'd1,
    ACT_ZERO    = 2'd2,
    ACT_RESTORE = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_DEGREE = 2'd1,
    ST_BUSY       = 2'd2
  } status_t;

  typedef enum logic {
    CFG_STEP_DELAY = 1'b0,
    CFG_MAX_ANGLE  = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic [1:0]          action;
    logic [DEGREE_W-1:0] degree;
    logic                direction;
  } item_in_t;

  typedef struct packed {
    logic [3:0]          coils;
    logic                busy_res;
    logic [DEGREE_W-1:0] position;
    logic                zeroed;
    logic [1:0]          status;
  } item_out_t;

  // bit3 blue, bit2 pink, bit1 yellow, bit0 orange
  function automatic logic [3:0] phase_pattern(input logic [PHASE_W-1:0] idx);
    logic [3:0] pat;
    case (idx)
      3'd0:    pat = 4'd8;
      3'd1:    pat = 4'd12;
      3'd2:    pat = 4'd4;
      3'd3:    pat = 4'd6;
      3'd4:    pat = 4'd2;
      3'd5:    pat = 4'd3;
      3'd6:    pat = 4'd1;
      3'd7:    pat = 4'd9;
      default: pat = 4'd0;
    endcase
    return pat;
  endfunction

endpackage

// ===== hdl/clamped_half_step_stepper_sequencer.sv =====
// half-step stepper sequencer: command/tick decode, motion state and result register
//
// Usage: each request on the input channel carries an action (tick, move, zero,
// restore), a degree and a direction. Every accepted request yields exactly one
// result on the output channel with the coil drive bits, busy flag, kept
// position, parked flag and a status code.
// Ticks advance the running motion: each coil pattern is held for step_delay
// ticks. Move, zero and restore are refused with a busy status while a motion runs.
// The result of a request is registered: it is valid right after the edge that
// takes the request. One request is accepted every cycle while in_stall is low;
// the state update and the sweep count multiply sit before the result register.
// A stalled result stays in the output register; in_stall rises only while that
// register is full and out_stall is high, so the input side keeps moving otherwise.
// The configuration channel writes step_delay (index 0) and max_angle (index 1);
// cfg_ready is always high. Writes must be made while the block is idle; not checked.
// Synchronous reset puts the motor parked at angle 0 with all coils off,
// step_delay 1000 and max_angle 90, and empties the output register.
module clamped_half_step_stepper_sequencer
  import chss_pkg::*;
#(
  parameter int unsigned HOLD_COUNTER_WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  item_in_t            in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output item_out_t           out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [DELAY_W-1:0]  cfg_data
);

  localparam int unsigned HW = HOLD_COUNTER_WIDTH;
  localparam int unsigned CW = (HW > DELAY_W) ? HW : DELAY_W;
  localparam logic [HW-1:0] HOLD_MAX = {HW{1'b1}};

  // configuration
  logic [DELAY_W-1:0]  step_delay;
  logic [DEGREE_W-1:0] max_angle;

  // motion state
  logic [DEGREE_W-1:0] angle, angle_next;
  logic                parked, parked_next;
  logic [SWEEP_W-1:0]  sweeps_left, sweeps_left_next;
  logic [PHASE_W-1:0]  phase_index, phase_index_next;
  logic                reverse, reverse_next;
  logic [HW-1:0]       hold_count, hold_count_next;
  logic [3:0]          coil_state, coil_state_next;
  logic                off_at_end, off_at_end_next;
  logic                running, running_next;

  logic                accept;
  status_t             status;
  item_out_t           result;

  logic [CW-1:0]       eff_delay;
  logic [HW-1:0]       hold_inc;
  logic                last_phase;
  logic [SWEEP_W-1:0]  sweeps_dec;
  logic [DEGREE_W-1:0] limit;
  logic [DEGREE_W:0]   fwd_sum;
  logic [DEGREE_W-1:0] actual;
  logic                start;
  logic [DEGREE_W-1:0] mot_deg;
  logic                mot_back;
  logic                mot_off;
  logic [PROD_W-1:0]   prod;
  logic [SWEEP_W-1:0]  sweeps;
  logic [PHASE_W-1:0]  start_phase;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;
  assign in_stall  = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_delay <= STEP_DELAY_RESET;
      max_angle  <= MAX_ANGLE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_STEP_DELAY: step_delay <= cfg_data;
        CFG_MAX_ANGLE:  max_angle  <= cfg_data[DEGREE_W-1:0];
        default:        ;
      endcase
    end
  end

  // delay of 0 acts as 1, and saturates at what the hold counter can reach
  always_comb begin
    eff_delay = CW'(step_delay);
    if (step_delay == '0) begin
      eff_delay = CW'(1);
    end else if (CW'(step_delay) > CW'(HOLD_MAX)) begin
      eff_delay = CW'(HOLD_MAX);
    end
  end

  assign limit       = (max_angle > DEGREES_PER_TURN) ? DEGREES_PER_TURN : max_angle;
  assign hold_inc    = hold_count + HW'(1);
  assign last_phase  = reverse ? (phase_index == '0) : (phase_index == PHASE_W'(PHASES - 1));
  assign sweeps_dec  = (sweeps_left != '0) ? (sweeps_left - SWEEP_W'(1)) : sweeps_left;
  assign fwd_sum     = {1'b0, angle} + {1'b0, in_data.degree};

  // one shared multiply for the sweep count of any motion
  assign prod        = PROD_W'(mot_deg) * PROD_W'(SWEEP_RECIP);
  assign sweeps      = prod[SWEEP_SHIFT +: SWEEP_W];
  assign start_phase = mot_back ? PHASE_W'(PHASES - 1) : '0;

  always_comb begin
    angle_next       = angle;
    parked_next      = parked;
    sweeps_left_next = sweeps_left;
    phase_index_next = phase_index;
    reverse_next     = reverse;
    hold_count_next  = hold_count;
    coil_state_next  = coil_state;
    off_at_end_next  = off_at_end;
    running_next     = running;
    status           = ST_OK;
    start            = 1'b0;
    mot_deg          = angle;
    mot_back         = 1'b0;
    mot_off          = 1'b0;
    actual           = in_data.degree;

    if (accept) begin
      case (action_t'(in_data.action))
        ACT_TICK: begin
          if (running) begin
            if (CW'(hold_inc) < eff_delay) begin
              hold_count_next = hold_inc;
            end else begin
              hold_count_next = '0;
              if (last_phase && sweeps_dec == '0) begin
                sweeps_left_next = sweeps_dec;
                running_next     = 1'b0;
                if (off_at_end) begin
                  coil_state_next = 4'd0;
                end
              end else begin
                if (last_phase) begin
                  sweeps_left_next = sweeps_dec;
                end
                phase_index_next = reverse ? (phase_index - PHASE_W'(1))
                                           : (phase_index + PHASE_W'(1));
                coil_state_next  = phase_pattern(phase_index_next);
              end
            end
          end
        end
        ACT_MOVE: begin
          if (running) begin
            status = ST_BUSY;
          end else if (in_data.degree == '0 || in_data.degree > DEGREES_PER_TURN) begin
            status = ST_BAD_DEGREE;
          end else if (!in_data.direction) begin
            if (angle < limit) begin
              if (fwd_sum > {1'b0, limit}) begin
                actual = limit - angle;
              end
              angle_next  = angle + actual;
              parked_next = (angle_next == '0);
              start       = 1'b1;
              mot_deg     = actual;
            end
          end else begin
            if (angle != '0) begin
              if (in_data.degree > angle) begin
                actual = angle;
              end
              angle_next  = angle - actual;
              parked_next = (angle_next == '0);
              start       = 1'b1;
              mot_deg     = actual;
              mot_back    = 1'b1;
            end
          end
        end
        ACT_ZERO: begin
          if (running) begin
            status = ST_BUSY;
          end else begin
            parked_next = 1'b1;
            if (!parked && angle != '0) begin
              start    = 1'b1;
              mot_back = 1'b1;
              mot_off  = 1'b1;
            end else begin
              coil_state_next = 4'd0;
            end
          end
        end
        ACT_RESTORE: begin
          if (running) begin
            status = ST_BUSY;
          end else begin
            parked_next = 1'b0;
            if (parked && angle != '0) begin
              start   = 1'b1;
              mot_off = 1'b1;
            end else begin
              coil_state_next = 4'd0;
            end
          end
        end
        default: ;
      endcase

      if (start) begin
        if (sweeps == '0) begin
          if (mot_off) begin
            coil_state_next = 4'd0;
          end
        end else begin
          sweeps_left_next = sweeps;
          reverse_next     = mot_back;
          off_at_end_next  = mot_off;
          phase_index_next = start_phase;
          hold_count_next  = '0;
          coil_state_next  = phase_pattern(start_phase);
          running_next     = 1'b1;
        end
      end
    end
  end

  always_comb begin
    result.coils    = coil_state_next;
    result.busy_res = running_next;
    result.position = angle_next;
    result.zeroed   = parked_next;
    result.status   = status;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      angle       <= '0;
      parked      <= 1'b1;
      sweeps_left <= '0;
      phase_index <= '0;
      reverse     <= 1'b0;
      hold_count  <= '0;
      coil_state  <= 4'd0;
      off_at_end  <= 1'b0;
      running     <= 1'b0;
    end else begin
      angle       <= angle_next;
      parked      <= parked_next;
      sweeps_left <= sweeps_left_next;
      phase_index <= phase_index_next;
      reverse     <= reverse_next;
      hold_count  <= hold_count_next;
      coil_state  <= coil_state_next;
      off_at_end  <= off_at_end_next;
      running     <= running_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= result;
    end
  end

endmodule

// ===== test/chss_checker.sv =====
// checker for the stepper sequencer: predicts each result and compares it with the output channel
module chss_checker
  import chss_pkg::*;
#(
  parameter int unsigned HOLD_COUNTER_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  item_in_t           in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  item_out_t          out_data,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [DELAY_W-1:0] cfg_data,
  output int                 mismatch_count,
  output int                 results_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned HOLD_MAX = (64'd1 << HOLD_COUNTER_WIDTH) - 64'd1;
  localparam logic [3:0] COIL_TABLE [0:7] = '{4'd8, 4'd12, 4'd4, 4'd6,
                                               4'd2, 4'd3, 4'd1, 4'd9};

  logic [DELAY_W-1:0]  delay_reg;
  logic [DEGREE_W-1:0] limit_reg;

  int unsigned     motor_angle;
  bit              parked;
  int unsigned     sweeps_left;
  int unsigned     phase_idx;
  bit              run_reverse;
  longint unsigned hold_ticks;
  logic [3:0]      coil_drive;
  bit              off_at_end;
  bit              motion_running;

  item_out_t result_queue[$];
  int        fault_total = 0;

  assign mismatch_count = fault_total;

  function automatic void begin_motion(input int unsigned deg, input bit back, input bit off);
    int unsigned sweeps;
    sweeps = (512 * deg) / 360;
    if (sweeps == 0) begin
      if (off) coil_drive = '0;
      return;
    end
    sweeps_left    = sweeps & 32'h3ff;
    run_reverse    = back;
    off_at_end     = off;
    phase_idx      = back ? 7 : 0;
    hold_ticks     = 0;
    coil_drive     = COIL_TABLE[phase_idx];
    motion_running = 1'b1;
  endfunction

  function automatic item_out_t predict_result(input item_in_t req);
    item_out_t       res;
    status_t         st;
    int unsigned     limit;
    int unsigned     span;
    longint unsigned eff_delay;
    bit              last_phase;
    bit              wind;
    st = ST_OK;
    case (action_t'(req.action))
      ACT_TICK: begin
        if (motion_running) begin
          eff_delay = (delay_reg == 0) ? 64'd1 : 64'(delay_reg);
          if (eff_delay > HOLD_MAX) eff_delay = HOLD_MAX;
          hold_ticks = (hold_ticks + 1) & HOLD_MAX;
          if (hold_ticks >= eff_delay) begin
            hold_ticks = 0;
            last_phase = run_reverse ? (phase_idx == 0) : (phase_idx == 7);
            if (last_phase && sweeps_left > 0) sweeps_left--;
            if (last_phase && sweeps_left == 0) begin
              motion_running = 1'b0;
              if (off_at_end) coil_drive = '0;
            end else begin
              phase_idx  = run_reverse ? (phase_idx + 7) % 8 : (phase_idx + 1) % 8;
              coil_drive = COIL_TABLE[phase_idx];
            end
          end
        end
      end
      ACT_MOVE: begin
        limit = (limit_reg > 360) ? 360 : limit_reg;
        span  = req.degree;
        if (motion_running) begin
          st = ST_BUSY;
        end else if (req.degree == 0 || req.degree > 360) begin
          st = ST_BAD_DEGREE;
        end else if (!req.direction) begin
          // forward moves stop at the angle limit, nothing happens at or past it
          if (motor_angle < limit) begin
            if (motor_angle + span > limit) span = limit - motor_angle;
            motor_angle += span;
            parked = (motor_angle == 0);
            begin_motion(span, 1'b0, 1'b0);
          end
        end else if (motor_angle != 0) begin
          if (span > motor_angle) span = motor_angle;
          motor_angle -= span;
          parked = (motor_angle == 0);
          begin_motion(span, 1'b1, 1'b0);
        end
      end
      default: begin
        if (motion_running) begin
          st = ST_BUSY;
        end else if (req.action == ACT_ZERO) begin
          wind   = !parked && motor_angle > 0;
          parked = 1'b1;
          if (wind) begin_motion(motor_angle, 1'b1, 1'b1);
          else coil_drive = '0;
        end else begin
          wind   = parked && motor_angle > 0;
          parked = 1'b0;
          if (wind) begin_motion(motor_angle, 1'b0, 1'b1);
          else coil_drive = '0;
        end
      end
    endcase
    res.coils    = coil_drive;
    res.busy_res = motion_running;
    res.position = motor_angle[DEGREE_W-1:0];
    res.zeroed   = parked;
    res.status   = st;
    return res;
  endfunction

  always @(posedge clk) begin
    item_out_t want;
    if (rst) begin
      delay_reg      = STEP_DELAY_RESET;
      limit_reg      = MAX_ANGLE_RESET;
      motor_angle    = 0;
      parked         = 1'b1;
      sweeps_left    = 0;
      phase_idx      = 0;
      run_reverse    = 1'b0;
      hold_ticks     = 0;
      coil_drive     = '0;
      off_at_end     = 1'b0;
      motion_running = 1'b0;
      result_queue.delete();
      results_pending <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (result_queue.size() == 0) begin
          if (fault_total < 10) begin
            $write("%0t: result with no request pending: coils=%h busy=%b pos=%0d",
                   $realtime, out_data.coils, out_data.busy_res, out_data.position);
            $display(" zeroed=%b status=%0d", out_data.zeroed, out_data.status);
          end
          fault_total++;
        end else begin
          want = result_queue.pop_front();
          if (out_data.coils !== want.coils || out_data.busy_res !== want.busy_res ||
              out_data.position !== want.position || out_data.zeroed !== want.zeroed ||
              out_data.status !== want.status) begin
            if (fault_total < 10) begin
              $write("%0t: mismatch: expected coils=%h busy=%b pos=%0d zeroed=%b status=%0d,",
                     $realtime, want.coils, want.busy_res, want.position, want.zeroed,
                     want.status);
              $display(" got coils=%h busy=%b pos=%0d zeroed=%b status=%0d",
                       out_data.coils, out_data.busy_res, out_data.position,
                       out_data.zeroed, out_data.status);
            end
            fault_total++;
          end
        end
      end
      // a request taken at the same edge as a register write still sees the old value
      if (in_valid && !in_stall) result_queue.push_back(predict_result(in_data));
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_STEP_DELAY) delay_reg = cfg_data;
        else limit_reg = cfg_data[DEGREE_W-1:0];
      end
      results_pending <= result_queue.size();
    end
  end

endmodule

// ===== test/clamped_half_step_stepper_sequencer_tb.sv =====
// testbench top for the stepper sequencer: clock, reset, request stimulus and verdict
module clamped_half_step_stepper_sequencer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import chss_pkg::*;

  localparam int IDLE_LIMIT   = 20000;
  localparam int PHASE_QUOTA  = 145;
  localparam int PHASE_COUNT  = 8;

  localparam logic [15:0] PHASE_DELAY [0:PHASE_COUNT-1] =
    '{16'd0, 16'd1, 16'd2, 16'd1, 16'd3, 16'd65535, 16'd1, 16'd1};
  // one max_angle value carries junk in the upper bits of the write data
  localparam logic [15:0] PHASE_LIMIT [0:PHASE_COUNT-1] =
    '{16'd360, 16'd45, 16'd511, 16'hFE1E, 16'd0, 16'd90, 16'd360, 16'd12};

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  item_in_t           in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  item_out_t          out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic               cfg_index = CFG_STEP_DELAY;
  logic [DELAY_W-1:0] cfg_data = '0;
  int                 mismatch_count;
  int                 results_pending;

  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int unsigned requests_sent  = 0;
  int          quiet_cycles   = 0;

  clamped_half_step_stepper_sequencer u_top (.*);
  chss_checker u_checker (.*);

  always #1 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= (recv_stall_pct > 0) && ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("clamped_half_step_stepper_sequencer_tb: FAIL");
      $finish;
    end
  end

  task automatic send_request(input action_t act, input logic [DEGREE_W-1:0] deg,
                              input logic dir);
    if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < send_idle_pct) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_data.action    <= act;
    in_data.degree    <= deg;
    in_data.direction <= dir;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    requests_sent++;
  endtask

  // ticks carry random degree and direction bits that the block must ignore
  task automatic tick_burst(input int unsigned count);
    repeat (count) send_request(ACT_TICK, DEGREE_W'($urandom_range(0, 511)),
                                1'($urandom_range(0, 1)));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_pending != 0);
  endtask

  task automatic program_config(input logic [15:0] delay, input logic [15:0] limit);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_index <= CFG_STEP_DELAY;
    cfg_data  <= delay;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= CFG_MAX_ANGLE;
    cfg_data  <= limit;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // commands followed by tick bursts so motions mostly run to completion
  task automatic run_traffic(input int unsigned quota);
    int unsigned first;
    int unsigned pick;
    int unsigned deg;
    int unsigned ticks;
    first = requests_sent;
    while (requests_sent - first < quota) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        pick = $urandom_range(0, 99);
        if (pick < 65) deg = $urandom_range(1, 6);
        else if (pick < 85) deg = $urandom_range(7, 360);
        else if (pick < 90) deg = 0;
        else if (pick < 95) deg = $urandom_range(361, 511);
        else deg = ($urandom_range(0, 1) != 0) ? 360 : 1;
        send_request(ACT_MOVE, DEGREE_W'(deg), 1'($urandom_range(0, 1)));
      end else if (pick < 70) begin
        send_request(ACT_ZERO, DEGREE_W'($urandom_range(0, 511)), 1'($urandom_range(0, 1)));
      end else if (pick < 85) begin
        send_request(ACT_RESTORE, DEGREE_W'($urandom_range(0, 511)),
                     1'($urandom_range(0, 1)));
      end else begin
        send_request(action_t'($urandom_range(0, 3)), DEGREE_W'($urandom_range(0, 511)),
                     1'($urandom_range(0, 1)));
      end
      // the last burst of a phase is cut to what is left of its quota
      ticks = $urandom_range(0, 150);
      if (requests_sent - first + ticks > quota) ticks = quota - (requests_sent - first);
      tick_burst(ticks);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset settings: bad degrees, parked zero/restore, moves clamped away
    send_request(ACT_TICK, 0, 0);
    send_request(ACT_MOVE, 0, 0);
    send_request(ACT_MOVE, 361, 0);
    send_request(ACT_MOVE, 511, 1);
    send_request(ACT_ZERO, 0, 0);
    send_request(ACT_RESTORE, 0, 0);
    send_request(ACT_ZERO, 0, 0);
    send_request(ACT_MOVE, 360, 1);
    // long motion, then every command while busy
    send_request(ACT_MOVE, 1, 0);
    send_request(ACT_MOVE, 5, 0);
    send_request(ACT_MOVE, 0, 1);
    send_request(ACT_ZERO, 0, 0);
    send_request(ACT_RESTORE, 0, 0);
    tick_burst(3);
    // zero delay acts as one, change lands mid motion
    program_config(16'd0, 16'd0);
    tick_burst(12);
    send_request(ACT_MOVE, 10, 0);
    program_config(16'd1, 16'd3);
    send_request(ACT_MOVE, 360, 0);
    tick_burst(20);
    send_request(ACT_ZERO, 0, 0);
    tick_burst(36);
    send_request(ACT_RESTORE, 0, 0);
    tick_burst(36);
    send_request(ACT_MOVE, 360, 1);
    tick_burst(36);
    send_request(ACT_RESTORE, 0, 0);

    for (int p = 0; p < PHASE_COUNT; p++) begin
      program_config(PHASE_DELAY[p], PHASE_LIMIT[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
        default: begin send_idle_pct = 35; recv_stall_pct = 35; end
      endcase
      run_traffic(PHASE_QUOTA);
    end

    drain_results();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0 && results_pending == 0)
      $display("clamped_half_step_stepper_sequencer_tb: PASS");
    else
      $display("clamped_half_step_stepper_sequencer_tb: FAIL");
    $finish;
  end

endmodule
